// ===== rtl/core/ccpp_pkg.sv =====
// Package for the constant pool parser: tag and result kind codes, the
// field size table and the record type carried from the front to the back.
// No dependencies.
`default_nettype none

package ccpp_pkg;

    // Constant pool tags.
    localparam logic [7:0] TAG_UTF8          = 8'd1;
    localparam logic [7:0] TAG_INTEGER       = 8'd3;
    localparam logic [7:0] TAG_FLOAT         = 8'd4;
    localparam logic [7:0] TAG_LONG          = 8'd5;
    localparam logic [7:0] TAG_DOUBLE        = 8'd6;
    localparam logic [7:0] TAG_CLASS         = 8'd7;
    localparam logic [7:0] TAG_STRING        = 8'd8;
    localparam logic [7:0] TAG_FIELDREF      = 8'd9;
    localparam logic [7:0] TAG_METHODREF     = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF    = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE   = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYN    = 8'd18;

    // Result kinds.
    localparam logic [1:0] KIND_ENTRY  = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_EXCESS = 2'd3;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One result as the front produces it; the back splits acc into fields.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] slot;
        logic [7:0]  tag;
        logic [63:0] acc;
        logic [7:0]  text;
        logic        last;
        logic        done;
    } t_qrec;

    // Number of field bytes after a tag; zero marks an unknown tag.
    function automatic logic [3:0] field_size(input logic [7:0] tag);
        logic [3:0] n;
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: n = 4'd2;
            TAG_METHOD_HANDLE: n = 4'd3;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
            TAG_NAME_AND_TYPE, TAG_INVOKE_DYN: n = 4'd4;
            TAG_LONG, TAG_DOUBLE: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccpp_if.sv =====
// Valid/ready channel interfaces for the pool byte input and the result output.
// No dependencies.
`default_nettype none

interface ccpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface ccpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] slot;
    logic [7:0]  entry_tag;
    logic [31:0] value_high;
    logic [31:0] value_low;
    logic [7:0]  text_byte;
    logic        last_text;
    logic        pool_done;

    modport source (output valid, output kind, output slot, output entry_tag,
                    output value_high, output value_low, output text_byte,
                    output last_text, output pool_done, input ready);
    modport sink   (input valid, input kind, input slot, input entry_tag,
                    input value_high, input value_low, input text_byte,
                    input last_text, input pool_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ccpp_front.sv =====
// Front of the parser: accepts pool bytes, runs the tag/field/text state
// machine and pushes result records. Depends on ccpp_pkg and ccpp_if.
`default_nettype none

module ccpp_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    ccpp_in_if.sink           i_in,
    input  wire               i_cfg_we,
    input  wire  [15:0]       i_cfg_wdata,
    input  wire               i_q_full,
    output logic              o_push,
    output ccpp_pkg::t_qrec   o_rec
);

    typedef enum logic [2:0] {
        PH_TAG, PH_FIELDS, PH_TEXTLEN, PH_TEXT, PH_EXHAUSTED
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_slot, n_slot;
    logic [7:0]  r_tag, n_tag;
    logic [3:0]  r_fbl, n_fbl;
    logic [63:0] r_shift, n_shift;
    logic [15:0] r_text_left, n_text_left;
    logic        r_halted, n_halted;
    logic [15:0] r_pool_count;

    logic accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        t_phase      e_phase;
        logic [15:0] e_slot;
        logic [3:0]  e_fbl;
        logic [63:0] e_shift;
        logic [15:0] e_tl;
        logic        e_halted;
        logic [3:0]  size;
        logic [63:0] sh_new;
        logic [3:0]  fbl_dec;
        logic [15:0] tl_dec;
        logic [16:0] next_slot;
        logic        wide;

        n_phase     = r_phase;
        n_slot      = r_slot;
        n_tag       = r_tag;
        n_fbl       = r_fbl;
        n_shift     = r_shift;
        n_text_left = r_text_left;
        n_halted    = r_halted;
        o_push      = 1'b0;
        o_rec       = '0;

        e_phase  = r_phase;
        e_slot   = r_slot;
        e_fbl    = r_fbl;
        e_shift  = r_shift;
        e_tl     = r_text_left;
        e_halted = r_halted;
        if (i_in.first_byte) begin
            e_phase  = PH_TAG;
            e_slot   = 16'd1;
            e_fbl    = 4'd0;
            e_shift  = 64'd0;
            e_tl     = 16'd0;
            e_halted = 1'b0;
        end

        size      = ccpp_pkg::field_size(i_in.data_byte);
        sh_new    = {e_shift[55:0], i_in.data_byte};
        fbl_dec   = (e_fbl != 4'd0) ? e_fbl - 4'd1 : 4'd0;
        tl_dec    = (e_tl != 16'd0) ? e_tl - 16'd1 : 16'd0;
        wide      = (r_tag == ccpp_pkg::TAG_LONG) || (r_tag == ccpp_pkg::TAG_DOUBLE);
        next_slot = {1'b0, e_slot} + (wide ? 17'd2 : 17'd1);

        if (accept) begin
            n_phase     = e_phase;
            n_slot      = e_slot;
            n_fbl       = e_fbl;
            n_shift     = e_shift;
            n_text_left = e_tl;
            n_halted    = e_halted;
            if (!e_halted) begin
                if (e_phase == PH_TAG && e_slot >= r_pool_count) begin
                    e_phase = PH_EXHAUSTED;
                end
                o_rec.slot = e_slot;
                o_rec.tag  = r_tag;
                case (e_phase)
                    PH_TAG: begin
                        n_tag   = i_in.data_byte;
                        n_shift = 64'd0;
                        if (size == 4'd0) begin
                            n_halted   = 1'b1;
                            o_push     = 1'b1;
                            o_rec.kind = ccpp_pkg::KIND_ERROR;
                            o_rec.tag  = i_in.data_byte;
                        end else begin
                            n_fbl   = size;
                            n_phase = (i_in.data_byte == ccpp_pkg::TAG_UTF8) ?
                                      PH_TEXTLEN : PH_FIELDS;
                        end
                    end
                    PH_FIELDS, PH_TEXTLEN: begin
                        n_shift = sh_new;
                        n_fbl   = fbl_dec;
                        if (fbl_dec == 4'd0) begin
                            o_push     = 1'b1;
                            o_rec.kind = ccpp_pkg::KIND_ENTRY;
                            o_rec.acc  = sh_new;
                            if (e_phase == PH_TEXTLEN && sh_new[15:0] != 16'd0) begin
                                // A text header leads into its content bytes.
                                n_text_left = sh_new[15:0];
                                n_phase     = PH_TEXT;
                            end else begin
                                if (e_phase == PH_TEXTLEN) begin
                                    n_text_left = 16'd0;
                                end
                                n_slot = next_slot[15:0];
                                if (next_slot >= {1'b0, r_pool_count}) begin
                                    n_phase    = PH_EXHAUSTED;
                                    o_rec.done = 1'b1;
                                end else begin
                                    n_phase = PH_TAG;
                                end
                            end
                        end
                    end
                    PH_TEXT: begin
                        n_text_left = tl_dec;
                        o_push      = 1'b1;
                        o_rec.kind  = ccpp_pkg::KIND_TEXT;
                        o_rec.text  = i_in.data_byte;
                        if (tl_dec == 16'd0) begin
                            o_rec.last = 1'b1;
                            n_slot     = next_slot[15:0];
                            if (next_slot >= {1'b0, r_pool_count}) begin
                                n_phase    = PH_EXHAUSTED;
                                o_rec.done = 1'b1;
                            end else begin
                                n_phase = PH_TAG;
                            end
                        end
                    end
                    default: begin
                        n_phase    = PH_EXHAUSTED;
                        o_push     = 1'b1;
                        o_rec.kind = ccpp_pkg::KIND_EXCESS;
                        o_rec.tag  = 8'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG;
            r_slot       <= 16'd1;
            r_tag        <= 8'd0;
            r_fbl        <= 4'd0;
            r_shift      <= 64'd0;
            r_text_left  <= 16'd0;
            r_halted     <= 1'b0;
            r_pool_count <= 16'd0;
        end else begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_tag       <= n_tag;
            r_fbl       <= n_fbl;
            r_shift     <= n_shift;
            r_text_left <= n_text_left;
            r_halted    <= n_halted;
            if (i_cfg_we) begin
                r_pool_count <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccpp_queue.sv =====
// Short queue of result records between the front and the back.
// Depends on ccpp_pkg.
`default_nettype none

module ccpp_queue #(
    parameter int DEPTH = ccpp_pkg::QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  ccpp_pkg::t_qrec  i_rec,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output ccpp_pkg::t_qrec  o_rec
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ccpp_pkg::t_qrec r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds its depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("front pushed a record into a full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

// ===== rtl/core/ccpp_back.sv =====
// Back of the parser: pops result records, splits the accumulated field bytes
// by tag and holds the result in the output register. Depends on ccpp_pkg, ccpp_if.
`default_nettype none

module ccpp_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_empty,
    input  ccpp_pkg::t_qrec  i_rec,
    output logic             o_pop,
    ccpp_out_if.source       o_out
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_slot;
    logic [7:0]  r_tag;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic [7:0]  r_text;
    logic        r_last;
    logic        r_done;

    logic [31:0] n_hi;
    logic [31:0] n_lo;

    assign o_pop = !i_q_empty && (!r_valid || o_out.ready);

    always_comb begin
        n_hi = 32'd0;
        n_lo = 32'd0;
        if (i_rec.kind == ccpp_pkg::KIND_ENTRY) begin
            case (i_rec.tag)
                ccpp_pkg::TAG_UTF8, ccpp_pkg::TAG_CLASS, ccpp_pkg::TAG_STRING,
                ccpp_pkg::TAG_METHOD_TYPE: begin
                    n_hi = {16'd0, i_rec.acc[15:0]};
                end
                ccpp_pkg::TAG_INTEGER, ccpp_pkg::TAG_FLOAT: begin
                    n_hi = i_rec.acc[31:0];
                end
                ccpp_pkg::TAG_LONG, ccpp_pkg::TAG_DOUBLE: begin
                    n_hi = i_rec.acc[63:32];
                    n_lo = i_rec.acc[31:0];
                end
                ccpp_pkg::TAG_METHOD_HANDLE: begin
                    n_hi = {24'd0, i_rec.acc[23:16]};
                    n_lo = {16'd0, i_rec.acc[15:0]};
                end
                default: begin
                    n_hi = {16'd0, i_rec.acc[31:16]};
                    n_lo = {16'd0, i_rec.acc[15:0]};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_rec.kind;
            r_slot <= i_rec.slot;
            r_tag  <= i_rec.tag;
            r_hi   <= n_hi;
            r_lo   <= n_lo;
            r_text <= i_rec.text;
            r_last <= i_rec.last;
            r_done <= i_rec.done;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.kind       = r_kind;
    assign o_out.slot       = r_slot;
    assign o_out.entry_tag  = r_tag;
    assign o_out.value_high = r_hi;
    assign o_out.value_low  = r_lo;
    assign o_out.text_byte  = r_text;
    assign o_out.last_text  = r_last;
    assign o_out.pool_done  = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/class_constant_pool_parser.sv =====
// Class file constant pool parser, top level; uses ccpp_pkg, ccpp_if, ccpp_front,
// ccpp_queue and ccpp_back.
// Throughput: one byte item per cycle while the queue has room, set by the front FSM.
// A result item is written into the queue when the byte that completes it is accepted,
// then loaded into the back's output register, where it is offered.
// Reset (synchronous, active low) clears parser state, pool_count and the queue at once.
`default_nettype none

module class_constant_pool_parser #(
    parameter int QUEUE_DEPTH = ccpp_pkg::QUEUE_DEPTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ccpp_in_if.sink      i_in,
    ccpp_out_if.source   o_out,
    input  wire          i_cfg_we,
    input  wire  [15:0]  i_cfg_wdata
);

    // The front takes one byte item per cycle as long as the queue has room. It
    // walks each entry through its tag, field and text phases and produces at most
    // one record per byte: an entry or text header, a text byte, an unknown tag
    // error or an excess byte past the last slot.
    //
    // The back turns a record into result fields: it splits the big-endian field
    // bytes by tag into value_high and value_low. Its output register lets the
    // front keep working while a result item waits on the output side, and the
    // queue absorbs stalls there until it is full, when the front stops taking bytes.

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    ccpp_pkg::t_qrec  push_rec;
    ccpp_pkg::t_qrec  head_rec;

    ccpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    ccpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (head_rec)
    );

    ccpp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_rec     (head_rec),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
